// ===== rtl/core/apt_pkg.sv =====
// Shared types and constants for the animation playback timeline.
// No dependencies; every other file of the block imports this package.
package apt_pkg;

  localparam int unsigned TIME_W  = 36;
  localparam int unsigned ELAP_W  = 20;
  localparam int unsigned RATE_W  = 11;
  localparam int unsigned LOOP_W  = 17;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned EVT_W   = 3;
  localparam int unsigned FRAME_W = 11;
  localparam int unsigned PROD_W  = ELAP_W + RATE_W;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CNT_W   = 6;

  localparam logic [OP_W-1:0] OP_TICK     = 4'd0;
  localparam logic [OP_W-1:0] OP_PLAY     = 4'd1;
  localparam logic [OP_W-1:0] OP_PAUSE    = 4'd2;
  localparam logic [OP_W-1:0] OP_STOP     = 4'd3;
  localparam logic [OP_W-1:0] OP_SEEK     = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_LOOP = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_RATE = 4'd6;
  localparam logic [OP_W-1:0] OP_HIDDEN   = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD_END = 4'd8;
  localparam logic [OP_W-1:0] OP_RESET    = 4'd9;

  localparam logic [MODE_W-1:0] MODE_READY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOPPED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ENDED   = 3'd4;

  localparam logic [EVT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVT_W-1:0] EV_PLAYING = 3'd1;
  localparam logic [EVT_W-1:0] EV_PAUSED  = 3'd2;
  localparam logic [EVT_W-1:0] EV_STOPPED = 3'd3;
  localparam logic [EVT_W-1:0] EV_LOOP    = 3'd4;
  localparam logic [EVT_W-1:0] EV_ENDED   = 3'd5;

  localparam logic [CIDX_W-1:0] CFG_DURATION = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LOOPS    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PAUSE_HD = 2'd2;

  localparam logic [RATE_W-1:0] RATE_MIN   = 11'd26;
  localparam logic [RATE_W-1:0] RATE_MAX   = 11'd1024;
  localparam logic [RATE_W-1:0] RATE_ONE   = 11'd256;
  localparam logic [LOOP_W-1:0] LOOPS_SAT  = '1;
  localparam logic [CNT_W-1:0]  DIV_LAST   = 6'd35;

  typedef struct packed {
    logic latch;
    logic exec;
    logic adv;
    logic endchk;
    logic div_step;
    logic scan_start;
    logic scan_cmp;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic end_hit;
    logic repeat_play;
    logic div_last;
    logic scan_need;
    logic scan_stop;
  } sts_t;

endpackage

// ===== rtl/core/apt_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on apt_pkg for the field widths.
interface apt_in_if;
  import apt_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ELAP_W-1:0]   elapsed_us;
  logic [TIME_W-1:0]   seek_time_us;
  logic                flag_value;
  logic [RATE_W-1:0]   rate_q8;
  logic [TIME_W-1:0]   frame_end_us;
  modport source (output valid, operation, elapsed_us, seek_time_us, flag_value,
                  rate_q8, frame_end_us, input ready);
  modport sink   (input valid, operation, elapsed_us, seek_time_us, flag_value,
                  rate_q8, frame_end_us, output ready);
endinterface

interface apt_out_if;
  import apt_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   run_state;
  logic [TIME_W-1:0]   position_us;
  logic [FRAME_W-1:0]  frame_index;
  logic                frame_changed;
  logic [EVT_W-1:0]    event_code;
  logic                seek_done;
  modport source (output valid, run_state, position_us, frame_index, frame_changed,
                  event_code, seek_done, input ready);
  modport sink   (input valid, run_state, position_us, frame_index, frame_changed,
                  event_code, seek_done, output ready);
endinterface

// ===== rtl/core/apt_ctrl.sv =====
// Sequencing state machine of the playback timeline.
// Depends on apt_pkg; drives apt_dp through ctl_t and reads sts_t.
module apt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  apt_pkg::sts_t sts,
  output apt_pkg::ctl_t ctl
);
  import apt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_ADV  = 9'b000000100,
    S_ENDC = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_SEL  = 9'b000100000,
    S_RD   = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        ctl.adv   = 1'b1;
        state_nxt = S_ENDC;
      end
      S_ENDC: begin
        ctl.endchk = 1'b1;
        state_nxt  = (sts.end_hit && sts.repeat_play) ? S_DIV : S_SEL;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SEL;
      end
      S_SEL: begin
        ctl.scan_start = 1'b1;
        state_nxt      = sts.scan_need ? S_RD : S_FIN;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ctl.scan_cmp = 1'b1;
        state_nxt    = sts.scan_stop ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (slot_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/apt_dp.sv =====
// Datapath of the playback timeline: state, frame end-time memory, advance
// multiplier, bit-serial modulo unit, frame scan and result registers. Uses apt_pkg.
module apt_dp #(
  parameter int unsigned MAX_FRAMES = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [apt_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [apt_pkg::TIME_W-1:0]    cfg_wdata,
  input  logic [apt_pkg::OP_W-1:0]      i_operation,
  input  logic [apt_pkg::ELAP_W-1:0]    i_elapsed_us,
  input  logic [apt_pkg::TIME_W-1:0]    i_seek_time_us,
  input  logic                          i_flag_value,
  input  logic [apt_pkg::RATE_W-1:0]    i_rate_q8,
  input  logic [apt_pkg::TIME_W-1:0]    i_frame_end_us,
  input  apt_pkg::ctl_t                 ctl,
  output apt_pkg::sts_t                 sts,
  output logic [apt_pkg::MODE_W-1:0]    o_run_state,
  output logic [apt_pkg::TIME_W-1:0]    o_position_us,
  output logic [apt_pkg::FRAME_W-1:0]   o_frame_index,
  output logic                          o_frame_changed,
  output logic [apt_pkg::EVT_W-1:0]     o_event_code,
  output logic                          o_seek_done
);
  import apt_pkg::*;

  localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_FRAMES);

  logic [TIME_W-1:0] dur_r;
  logic [LOOP_W-1:0] iloops_r;
  logic              pwh_r;

  logic [OP_W-1:0]   op_r;
  logic [ELAP_W-1:0] elap_r;
  logic [TIME_W-1:0] seek_r;
  logic              flag_r;
  logic [RATE_W-1:0] rin_r;
  logic [TIME_W-1:0] fend_r;

  logic [MODE_W-1:0] mode_r;
  logic [TIME_W-1:0] pos_r;
  logic [LOOP_W-1:0] loops_r;
  logic              loop_en_r;
  logic              loop_user_r;
  logic [RATE_W-1:0] rate_r;
  logic              hidden_r;
  logic              seekw_r;
  logic [CW-1:0]     loaded_r;
  logic [IW-1:0]     shown_r;
  logic [IW-1:0]     prev_r;
  logic [EVT_W-1:0]  evt_r;
  logic [PROD_W-1:0] prod_r;

  logic [TIME_W:0]   rem_r;
  logic [TIME_W-1:0] dvd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_nxt;

  logic [IW-1:0]     idx_r;
  logic [TIME_W-1:0] rd_r;
  logic [TIME_W-1:0] mem [MAX_FRAMES];

  logic [TIME_W:0]   sum;
  logic [LOOP_W-1:0] loops_inc;
  logic [RATE_W-1:0] rate_clamp;

  assign sum       = {1'b0, pos_r} + (TIME_W + 1)'(prod_r[PROD_W-1:8]);
  assign loops_inc = (loops_r == LOOPS_SAT) ? loops_r : loops_r + 1'b1;
  assign rate_clamp = (rin_r < RATE_MIN) ? RATE_MIN : ((rin_r > RATE_MAX) ? RATE_MAX : rin_r);
  assign rem_sh    = {rem_r[TIME_W-1:0], dvd_r[TIME_W-1]};
  assign rem_nxt   = (rem_sh >= {1'b0, dur_r}) ? rem_sh - {1'b0, dur_r} : rem_sh;

  assign sts.end_hit     = (dur_r != '0) && (pos_r >= dur_r) && (mode_r == MODE_PLAYING);
  assign sts.repeat_play = loop_en_r && (loop_user_r || (iloops_r == '0) ||
                                         (loops_inc < iloops_r));
  assign sts.div_last    = (cnt_r == DIV_LAST);
  assign sts.scan_need   = (!hidden_r || seekw_r) && (loaded_r != '0);
  assign sts.scan_stop   = (rd_r > pos_r) || (CW'(idx_r) == loaded_r - 1'b1);

  always_ff @(posedge clk) begin
    if (op_r == OP_LOAD_END && ctl.exec && loaded_r < FULL) begin
      mem[loaded_r[IW-1:0]] <= fend_r;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_r   <= i_operation;
      elap_r <= i_elapsed_us;
      seek_r <= i_seek_time_us;
      flag_r <= i_flag_value;
      rin_r  <= i_rate_q8;
      fend_r <= i_frame_end_us;
    end
    if (ctl.exec) begin
      prod_r <= PROD_W'({{RATE_W{1'b0}}, elap_r} * {{ELAP_W{1'b0}}, rate_r});
    end
    if (ctl.endchk) begin
      rem_r <= '0;
      dvd_r <= pos_r;
      cnt_r <= '0;
    end else if (ctl.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[TIME_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctl.scan_start) begin
      idx_r <= '0;
    end else if (ctl.scan_cmp && !sts.scan_stop) begin
      idx_r <= idx_r + 1'b1;
    end
    if (ctl.finish) begin
      o_run_state     <= mode_r;
      o_position_us   <= pos_r;
      o_frame_index   <= FRAME_W'(shown_r);
      o_frame_changed <= (shown_r != prev_r);
      o_event_code    <= evt_r;
      o_seek_done     <= seekw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r       <= '0;
      iloops_r    <= LOOP_W'(1);
      pwh_r       <= 1'b1;
      mode_r      <= MODE_READY;
      pos_r       <= '0;
      loops_r     <= '0;
      loop_en_r   <= 1'b1;
      loop_user_r <= 1'b0;
      rate_r      <= RATE_ONE;
      hidden_r    <= 1'b0;
      seekw_r     <= 1'b0;
      loaded_r    <= '0;
      shown_r     <= '0;
      prev_r      <= '0;
      evt_r       <= EV_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DURATION: dur_r    <= cfg_wdata;
          CFG_LOOPS:    iloops_r <= cfg_wdata[LOOP_W-1:0];
          CFG_PAUSE_HD: pwh_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (ctl.latch) begin
        prev_r <= shown_r;
        evt_r  <= EV_NONE;
      end
      if (ctl.exec) begin
        unique case (op_r)
          OP_PLAY: begin
            if (mode_r == MODE_ENDED) begin
              pos_r   <= '0;
              loops_r <= '0;
            end
            mode_r <= MODE_PLAYING;
            evt_r  <= EV_PLAYING;
          end
          OP_PAUSE: begin
            mode_r <= MODE_PAUSED;
            evt_r  <= EV_PAUSED;
          end
          OP_STOP: begin
            mode_r  <= MODE_STOPPED;
            pos_r   <= '0;
            loops_r <= '0;
            if (loaded_r != '0) shown_r <= '0;
            evt_r   <= EV_STOPPED;
          end
          OP_SEEK: begin
            pos_r   <= (seek_r < dur_r) ? seek_r : dur_r;
            seekw_r <= 1'b1;
          end
          OP_SET_LOOP: begin
            loop_en_r   <= flag_r;
            loop_user_r <= 1'b1;
            loops_r     <= '0;
          end
          OP_SET_RATE: rate_r <= rate_clamp;
          OP_HIDDEN:   hidden_r <= flag_r;
          OP_LOAD_END: begin
            if (loaded_r < FULL) loaded_r <= loaded_r + 1'b1;
          end
          OP_RESET: begin
            mode_r      <= MODE_READY;
            pos_r       <= '0;
            loops_r     <= '0;
            loop_en_r   <= 1'b1;
            loop_user_r <= 1'b0;
            rate_r      <= RATE_ONE;
            hidden_r    <= 1'b0;
            seekw_r     <= 1'b0;
            loaded_r    <= '0;
            shown_r     <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.adv && op_r == OP_TICK && mode_r == MODE_PLAYING && !(hidden_r && pwh_r)) begin
        pos_r <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      end
      if (ctl.endchk && sts.end_hit) begin
        loops_r <= loops_inc;
        if (!sts.repeat_play) begin
          pos_r  <= dur_r;
          mode_r <= MODE_ENDED;
          evt_r  <= EV_ENDED;
        end
      end
      if (ctl.div_step && sts.div_last) begin
        pos_r <= rem_nxt[TIME_W-1:0];
        evt_r <= EV_LOOP;
      end
      if (ctl.scan_cmp && sts.scan_stop) begin
        shown_r <= idx_r;
      end
      if (ctl.finish) begin
        seekw_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/animation_playback_timeline.sv =====
// Top level of the animation playback timeline; needs apt_pkg, apt_if, apt_ctrl, apt_dp.
// One beat at a time: exec, advance, end check, bit-serial modulo steps on a loop wrap,
// a read and compare per frame entry scanned (at most the frames loaded); the result is
// registered once the output slot is free, then the next beat is accepted. Synchronous
// active-low reset clears all timeline state and the configuration registers to their
// defaults; the end-time memory is not cleared and is read only below the fill count.
module animation_playback_timeline #(
  parameter int unsigned MAX_FRAMES = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  apt_in_if.sink                        in_bus,
  apt_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [apt_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [apt_pkg::TIME_W-1:0]    cfg_wdata
);
  import apt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  apt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  apt_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .i_operation     (in_bus.operation),
    .i_elapsed_us    (in_bus.elapsed_us),
    .i_seek_time_us  (in_bus.seek_time_us),
    .i_flag_value    (in_bus.flag_value),
    .i_rate_q8       (in_bus.rate_q8),
    .i_frame_end_us  (in_bus.frame_end_us),
    .ctl             (ctl),
    .sts             (sts),
    .o_run_state     (out_bus.run_state),
    .o_position_us   (out_bus.position_us),
    .o_frame_index   (out_bus.frame_index),
    .o_frame_changed (out_bus.frame_changed),
    .o_event_code    (out_bus.event_code),
    .o_seek_done     (out_bus.seek_done)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("beat accepted while an item was in progress");

  a_end_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.event_code == EV_ENDED) |-> (out_bus.run_state == MODE_ENDED))
    else $error("ended event without ended state");

  a_loop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.event_code == EV_LOOP) |-> (out_bus.run_state == MODE_PLAYING))
    else $error("loop event while not playing");

  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.latch, ctl.exec, ctl.adv, ctl.endchk, ctl.div_step,
              ctl.scan_start, ctl.scan_cmp, ctl.finish}))
    else $error("more than one datapath step commanded");

endmodule
